/* rtl/rfag_pkg.sv */
package rfag_pkg;

  localparam int FRAME_WIDTH  = 320;
  localparam int FRAME_HEIGHT = 240;
  localparam int ROW_SHIFT    = 9;

  localparam int COORD_W = 12;
  localparam int COL_W   = ROW_SHIFT;
  localparam int ROW_W   = 8;
  localparam int COLOR_W = 16;
  localparam int ADDR_W  = ROW_W + COL_W;

  localparam int IN_DATA_W  = 4 * COORD_W + COLOR_W;
  localparam int OUT_DATA_W = ((ADDR_W + COLOR_W + 7) / 8) * 8;

  localparam logic signed [COORD_W-1:0] COL_MAX = COORD_W'(FRAME_WIDTH - 1);
  localparam logic signed [COORD_W-1:0] ROW_MAX = COORD_W'(FRAME_HEIGHT - 1);

  typedef enum logic {
    KIND_BOX  = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  // Item after clamping, as held in the input register
  typedef struct packed {
    kind_t              kind;
    logic [COL_W-1:0]   ax;
    logic [ROW_W-1:0]   ay;
    logic [COL_W-1:0]   bx;
    logic [ROW_W-1:0]   by;
    logic [COLOR_W-1:0] color;
  } item_t;

  function automatic logic [COL_W-1:0] clamp_col(input logic signed [COORD_W-1:0] v);
    logic [COL_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > COL_MAX) begin
      res = COL_MAX[COL_W-1:0];
    end else begin
      res = v[COL_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [ROW_W-1:0] clamp_row(input logic signed [COORD_W-1:0] v);
    logic [ROW_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > ROW_MAX) begin
      res = ROW_MAX[ROW_W-1:0];
    end else begin
      res = v[ROW_W-1:0];
    end
    return res;
  endfunction

endpackage

/* rtl/rfag_in_stage.sv */
module rfag_in_stage
  import rfag_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,
  output logic                 item_valid,
  output item_t                item,
  input  logic                 item_ready
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  item_t item_nxt;
  logic  accept;

  assign in_tready = !valid_r || item_ready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    item_nxt.kind  = kind_t'(in_tuser);
    item_nxt.ax    = clamp_col(in_tdata[COORD_W-1:0]);
    item_nxt.ay    = clamp_row(in_tdata[2*COORD_W-1:COORD_W]);
    item_nxt.bx    = clamp_col(in_tdata[3*COORD_W-1:2*COORD_W]);
    item_nxt.by    = clamp_row(in_tdata[4*COORD_W-1:3*COORD_W]);
    item_nxt.color = in_tdata[4*COORD_W+COLOR_W-1:4*COORD_W];
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (item_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* rtl/rfag_walker.sv */
module rfag_walker
  import rfag_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  item_t              item,
  output logic               item_ready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [ADDR_W-1:0]  out_addr,
  output logic [COLOR_W-1:0] out_color,
  output logic               out_tlast
);

  logic               busy_r,   busy_nxt;
  logic [ROW_W-1:0]   row_r,    row_nxt;
  logic [COL_W-1:0]   col_r,    col_nxt;
  logic [COL_W-1:0]   left_r,   left_nxt;
  logic [COL_W-1:0]   right_r,  right_nxt;
  logic [ROW_W-1:0]   bottom_r, bottom_nxt;
  logic [COLOR_W-1:0] color_r,  color_nxt;

  logic               ovalid_r, ovalid_nxt;
  logic [ADDR_W-1:0]  oaddr_r;
  logic [COLOR_W-1:0] ocolor_r;
  logic               olast_r;

  logic slot_free;
  logic is_box;
  logic emit;
  logic last;

  assign slot_free  = !ovalid_r || out_tready;
  assign is_box     = (item.kind == KIND_BOX);
  // A box command or an idle tick never needs the output slot
  assign item_ready = is_box || !busy_r || slot_free;
  assign emit       = item_valid && !is_box && busy_r && slot_free;
  assign last       = (col_r == right_r) && (row_r == bottom_r);

  always_comb begin
    busy_nxt   = busy_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    left_nxt   = left_r;
    right_nxt  = right_r;
    bottom_nxt = bottom_r;
    color_nxt  = color_r;
    if (item_valid && is_box) begin
      left_nxt   = (item.bx < item.ax) ? item.bx : item.ax;
      right_nxt  = (item.bx < item.ax) ? item.ax : item.bx;
      row_nxt    = (item.by < item.ay) ? item.by : item.ay;
      bottom_nxt = (item.by < item.ay) ? item.ay : item.by;
      col_nxt    = left_nxt;
      color_nxt  = item.color;
      busy_nxt   = 1'b1;
    end else if (emit) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else if (col_r == right_r) begin
        col_nxt = left_r;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end

    if (emit) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end else begin
      ovalid_nxt = ovalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      row_r    <= '0;
      col_r    <= '0;
      left_r   <= '0;
      right_r  <= '0;
      bottom_r <= '0;
      color_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      left_r   <= left_nxt;
      right_r  <= right_nxt;
      bottom_r <= bottom_nxt;
      color_r  <= color_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Column fits below the row shift, so the address is a concatenation
  always_ff @(posedge clk) begin
    if (emit) begin
      oaddr_r  <= {row_r, col_r};
      ocolor_r <= color_r;
      olast_r  <= last;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_addr   = oaddr_r;
  assign out_color  = ocolor_r;
  assign out_tlast  = olast_r;

endmodule

/* rtl/rectangle_fill_address_generator_top.sv */
// Rectangle fill address generator. Send a box command (in_tuser = 0) with two
// corners and a color; corners are clamped into the 320 x 240 frame and ordered.
// Each following tick (in_tuser = 1) yields one pixel write, scanning the box row
// by row from its top-left corner; out_tlast marks the final write, after which
// ticks yield nothing until the next command. A command replaces any running box.
// Throughput is one transaction per clock on each side while out_tready is high:
// the input register holds the clamped item, the walker updates its row and column
// counters and fills the output register in the same cycle, and a tick passes the
// input register, then the output register. The address is row * 512 + column.
module rectangle_fill_address_generator_top
  import rfag_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // corner_a_x[11:0], corner_a_y[23:12], corner_b_x[35:24], corner_b_y[47:36],
  // fill_color[63:48]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // kind: 0 box command, 1 tick
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // pixel_address[16:0], pixel_value[32:17], zero fill above
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  logic               item_valid;
  item_t              item;
  logic               item_ready;
  logic [ADDR_W-1:0]  out_addr;
  logic [COLOR_W-1:0] out_color;

  rfag_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready)
  );

  rfag_walker u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_addr   (out_addr),
    .out_color  (out_color),
    .out_tlast  (out_tlast)
  );

  assign out_tdata = {{(OUT_DATA_W - ADDR_W - COLOR_W){1'b0}}, out_color, out_addr};

endmodule
